### rtl/core/svpwm_pkg.sv
`default_nettype none

package svpwm_pkg;

  // fixed design constants
  localparam int unsigned CHANNELS        = 16;
  localparam int unsigned TICK_RESOLUTION = 4096;
  localparam int unsigned OSC_HZ          = 25000000;
  localparam int unsigned FREQ_MIN        = 24;
  localparam int unsigned FREQ_MAX        = 1526;
  localparam int unsigned PULSE_LO        = 500;
  localparam int unsigned PULSE_HI        = 2500;
  localparam int unsigned TICK_MAX        = 4095;
  localparam int unsigned ROUND_HALF      = 500000;
  localparam longint unsigned US_PER_S    = 64'd1000000;
  localparam longint unsigned SAT_X       = (64'd1 + TICK_MAX) * US_PER_S;

  // register write constants
  localparam logic [7:0] REG_LED0 = 8'd6;
  localparam logic [7:0] REG_ALL  = 8'hFA;
  localparam logic [7:0] FULL_OFF = 8'h10;

  // field widths
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 17;
  localparam int FREQ_W    = 11;
  localparam int TICK_W    = 12;

  // angle divider: quotient never exceeds the 16 bit pulse span
  localparam int QW    = 16;
  localparam int REM_W = 35;

  // tick conversion: x = us * f * res + half, reciprocal of 1e6 at 2^52
  localparam int XW         = 40;
  localparam int RECIP_SH   = 52;
  localparam longint unsigned RECIP = ((64'd1 << RECIP_SH) + US_PER_S - 64'd1) / US_PER_S;

  // prescaler divider
  localparam int DEN_W = 27;
  localparam int PQW   = 13;
  localparam int DSH_W = DEN_W + PQW - 1;

  localparam int FIFO_DEPTH = 4;

  typedef enum logic [2:0] {
    CMD_ANGLE   = 3'd0,
    CMD_PULSE   = 3'd1,
    CMD_RAW     = 3'd2,
    CMD_DIS_CH  = 3'd3,
    CMD_DIS_ALL = 3'd4,
    CMD_NEUTRAL = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_NOT_CONFIGURED = 2'd1,
    ST_BAD_CHANNEL    = 2'd2,
    ST_BAD_ARG        = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_ENABLED       = 3'd0,
    CFG_PWM_FREQUENCY = 3'd1,
    CFG_ANGLE_MIN     = 3'd2,
    CFG_ANGLE_MAX     = 3'd3,
    CFG_PULSE_MIN     = 3'd4,
    CFG_PULSE_MAX     = 3'd5,
    CFG_PULSE_NEUTRAL = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    JOB_FAIL,
    JOB_ANGLE,
    JOB_PULSE,
    JOB_RAW,
    JOB_OFF
  } job_kind_t;

  typedef enum logic [1:0] {
    PS_LOAD,
    PS_INIT,
    PS_RUN,
    PS_DONE
  } ps_state_t;

  typedef struct packed {
    logic                enabled;
    logic [FREQ_W-1:0]   pwm_frequency;
    logic signed [16:0]  angle_min;
    logic signed [16:0]  angle_max;
    logic [15:0]         pulse_min;
    logic [15:0]         pulse_max;
    logic [15:0]         pulse_neutral;
  } cfg_t;

  // classified command handed from front to back
  typedef struct packed {
    job_kind_t          kind;
    status_t            status;
    logic [7:0]         addr;
    logic [15:0]        pulse_req;
    logic [TICK_W-1:0]  on_raw;
    logic [TICK_W-1:0]  off_raw;
    logic [16:0]        angle_off;
  } job_t;

  typedef struct packed {
    logic [1:0] status;
    logic       write_valid;
    logic [7:0] reg_addr;
    logic [7:0] on_low;
    logic [7:0] on_high;
    logic [7:0] off_low;
    logic [7:0] off_high;
    logic [7:0] prescale;
  } out_t;

  function automatic logic [FREQ_W-1:0] freq_sat(input logic [FREQ_W-1:0] f);
    logic [FREQ_W-1:0] r;
    if (f < FREQ_W'(FREQ_MIN)) begin
      r = FREQ_W'(FREQ_MIN);
    end else if (f > FREQ_W'(FREQ_MAX)) begin
      r = FREQ_W'(FREQ_MAX);
    end else begin
      r = f;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/svpwm_if.sv
`default_nettype none

// command channel
interface svpwm_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [7:0]         channel;
  logic signed [16:0] angle;
  logic [15:0]        pulse_width;
  logic [15:0]        on_count;
  logic [15:0]        off_count;

  modport source (output valid, cmd, channel, angle, pulse_width, on_count, off_count,
                  input ready);
  modport sink (input valid, cmd, channel, angle, pulse_width, on_count, off_count,
                output ready);
endinterface

// register write channel
interface svpwm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       write_valid;
  logic [7:0] reg_addr;
  logic [7:0] on_low;
  logic [7:0] on_high;
  logic [7:0] off_low;
  logic [7:0] off_high;
  logic [7:0] prescale;

  modport source (output valid, status, write_valid, reg_addr, on_low, on_high, off_low,
                  off_high, prescale, input ready);
  modport sink (input valid, status, write_valid, reg_addr, on_low, on_high, off_low,
                off_high, prescale, output ready);
endinterface

`default_nettype wire

### rtl/core/servo_command_to_pwm_registers.sv
// channel | dir | handshake     | payload
// in_ch   | in  | valid/ready   | cmd, channel, angle, pulse_width, on_count, off_count
// out_ch  | out | valid/ready   | status, write_valid, reg_addr, on/off bytes, prescale
// cfg_*   | in  | write enable  | cfg_index, cfg_wdata
//
// one transaction per cycle sustained while out_ch.ready stays high and the prescaler is
// ready; the back pipeline holds the 16 stage angle divider and the tick conversion stages
// rst_n is synchronous; after reset and after every pwm_frequency write the prescaler
// divider runs through its load, init and run states, during which in_ch.ready is low
// a stalled output holds the whole back pipeline; the 4 entry queue takes input until full

`default_nettype none

module servo_command_to_pwm_registers (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [svpwm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [svpwm_pkg::CFG_W-1:0]       cfg_wdata,
  svpwm_in_if.sink                               in_ch,
  svpwm_out_if.source                            out_ch
);

  svpwm_pkg::cfg_t cfg_r, cfg_nxt;
  logic            freq_write;
  logic            presc_ready;
  logic [7:0]      prescale;
  logic            push, pop, fifo_full, fifo_empty;
  svpwm_pkg::job_t push_job, pop_job;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        svpwm_pkg::CFG_ENABLED:       cfg_nxt.enabled       = cfg_wdata[0];
        svpwm_pkg::CFG_PWM_FREQUENCY: cfg_nxt.pwm_frequency = cfg_wdata[svpwm_pkg::FREQ_W-1:0];
        svpwm_pkg::CFG_ANGLE_MIN:     cfg_nxt.angle_min     = cfg_wdata;
        svpwm_pkg::CFG_ANGLE_MAX:     cfg_nxt.angle_max     = cfg_wdata;
        svpwm_pkg::CFG_PULSE_MIN:     cfg_nxt.pulse_min     = cfg_wdata[15:0];
        svpwm_pkg::CFG_PULSE_MAX:     cfg_nxt.pulse_max     = cfg_wdata[15:0];
        svpwm_pkg::CFG_PULSE_NEUTRAL: cfg_nxt.pulse_neutral = cfg_wdata[15:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled       <= 1'b0;
      cfg_r.pwm_frequency <= 11'd50;
      cfg_r.angle_min     <= 17'sd0;
      cfg_r.angle_max     <= 17'sd18000;
      cfg_r.pulse_min     <= 16'd500;
      cfg_r.pulse_max     <= 16'd2500;
      cfg_r.pulse_neutral <= 16'd1500;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign freq_write = cfg_we && (cfg_index == svpwm_pkg::CFG_PWM_FREQUENCY);

  svpwm_presc u_presc (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (freq_write),
    .freq     (cfg_r.pwm_frequency),
    .ready    (presc_ready),
    .prescale (prescale)
  );

  svpwm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .presc_ready (presc_ready),
    .fifo_full   (fifo_full),
    .in_ch       (in_ch),
    .push        (push),
    .job         (push_job)
  );

  svpwm_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  svpwm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .prescale   (prescale),
    .fifo_empty (fifo_empty),
    .fifo_job   (pop_job),
    .fifo_pop   (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

### rtl/core/svpwm_presc.sv
`default_nettype none

module svpwm_presc (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            restart,
  input  wire logic [svpwm_pkg::FREQ_W-1:0]    freq,
  output logic                                 ready,
  output logic [7:0]                           prescale
);

  localparam int DEN_W = svpwm_pkg::DEN_W;
  localparam int DSH_W = svpwm_pkg::DSH_W;
  localparam int PQW   = svpwm_pkg::PQW;
  localparam int CW    = $clog2(PQW);

  svpwm_pkg::ps_state_t state_r, state_nxt;

  logic             load_en, init_en, run_en;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DSH_W-1:0] dsh_r;
  logic [PQW-1:0]   q_r;
  logic [CW-1:0]    cnt_r;
  logic             ge;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      svpwm_pkg::PS_LOAD: state_nxt = svpwm_pkg::PS_INIT;
      svpwm_pkg::PS_INIT: state_nxt = svpwm_pkg::PS_RUN;
      svpwm_pkg::PS_RUN: begin
        if (cnt_r == CW'(PQW - 1)) begin
          state_nxt = svpwm_pkg::PS_DONE;
        end
      end
      svpwm_pkg::PS_DONE: state_nxt = svpwm_pkg::PS_DONE;
      default: state_nxt = svpwm_pkg::PS_LOAD;
    endcase
    if (restart) begin
      state_nxt = svpwm_pkg::PS_LOAD;
    end
  end

  // state outputs
  always_comb begin
    load_en = 1'b0;
    init_en = 1'b0;
    run_en  = 1'b0;
    ready   = 1'b0;
    case (state_r)
      svpwm_pkg::PS_LOAD: load_en = 1'b1;
      svpwm_pkg::PS_INIT: init_en = 1'b1;
      svpwm_pkg::PS_RUN:  run_en  = 1'b1;
      svpwm_pkg::PS_DONE: ready   = 1'b1;
      default: ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= svpwm_pkg::PS_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // restoring division of osc + den/2 by den, one quotient bit a cycle
  assign ge      = DSH_W'(rem_r) >= dsh_r;
  assign rem_nxt = ge ? rem_r - DEN_W'(dsh_r) : rem_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      den_r <= DEN_W'(svpwm_pkg::TICK_RESOLUTION) * DEN_W'(svpwm_pkg::freq_sat(freq));
    end
    if (init_en) begin
      rem_r <= DEN_W'(svpwm_pkg::OSC_HZ) + (den_r >> 1);
      dsh_r <= DSH_W'(den_r) << (PQW - 1);
      q_r   <= '0;
      cnt_r <= '0;
    end
    if (run_en) begin
      rem_r <= rem_nxt;
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[PQW-2:0], ge};
      cnt_r <= cnt_r + CW'(1);
    end
  end

  // quotient minus one, saturated to a byte
  always_comb begin
    if (q_r == '0) begin
      prescale = 8'd0;
    end else if (q_r > PQW'(256)) begin
      prescale = 8'd255;
    end else begin
      prescale = 8'(q_r - PQW'(1));
    end
  end

  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == svpwm_pkg::PS_RUN |-> cnt_r < CW'(PQW))
    else $error("prescaler divider ran past its last quotient bit");

endmodule

`default_nettype wire

### rtl/core/svpwm_front.sv
`default_nettype none

module svpwm_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire svpwm_pkg::cfg_t cfg,
  input  wire logic            presc_ready,
  input  wire logic            fifo_full,
  svpwm_in_if.sink             in_ch,
  output logic                 push,
  output svpwm_pkg::job_t      job
);

  logic               chan_ok, range_ok, raw_ok;
  logic signed [16:0] ang_clamp;
  logic signed [17:0] ang_diff;

  assign in_ch.ready = !fifo_full && presc_ready;
  assign push        = in_ch.valid && in_ch.ready;

  // argument checks
  assign chan_ok  = in_ch.channel < 8'(svpwm_pkg::CHANNELS);
  assign range_ok = ($signed(cfg.angle_max) > $signed(cfg.angle_min)) &&
                    (cfg.pulse_max > cfg.pulse_min);
  assign raw_ok   = (in_ch.on_count <= 16'(svpwm_pkg::TICK_MAX)) &&
                    (in_ch.off_count <= 16'(svpwm_pkg::TICK_MAX));

  // clamp angle into the servo range and take its offset from the low end
  always_comb begin
    if ($signed(in_ch.angle) < $signed(cfg.angle_min)) begin
      ang_clamp = cfg.angle_min;
    end else if ($signed(in_ch.angle) > $signed(cfg.angle_max)) begin
      ang_clamp = cfg.angle_max;
    end else begin
      ang_clamp = in_ch.angle;
    end
    ang_diff = {ang_clamp[16], ang_clamp} - {cfg.angle_min[16], cfg.angle_min};
  end

  // classify the transaction
  always_comb begin
    job           = '0;
    job.kind      = svpwm_pkg::JOB_FAIL;
    job.status    = svpwm_pkg::ST_OK;
    job.addr      = svpwm_pkg::REG_LED0 + {in_ch.channel[5:0], 2'b00};
    job.pulse_req = in_ch.pulse_width;
    job.on_raw    = in_ch.on_count[svpwm_pkg::TICK_W-1:0];
    job.off_raw   = in_ch.off_count[svpwm_pkg::TICK_W-1:0];
    job.angle_off = ang_diff[16:0];
    if (!cfg.enabled) begin
      job.status = svpwm_pkg::ST_NOT_CONFIGURED;
    end else if (in_ch.cmd > svpwm_pkg::CMD_NEUTRAL) begin
      job.status = svpwm_pkg::ST_BAD_ARG;
    end else if (in_ch.cmd != svpwm_pkg::CMD_DIS_ALL && !chan_ok) begin
      job.status = svpwm_pkg::ST_BAD_CHANNEL;
    end else begin
      case (in_ch.cmd)
        svpwm_pkg::CMD_ANGLE: begin
          if (range_ok) begin
            job.kind = svpwm_pkg::JOB_ANGLE;
          end else begin
            job.status = svpwm_pkg::ST_BAD_ARG;
          end
        end
        svpwm_pkg::CMD_PULSE: job.kind = svpwm_pkg::JOB_PULSE;
        svpwm_pkg::CMD_RAW: begin
          if (raw_ok) begin
            job.kind = svpwm_pkg::JOB_RAW;
          end else begin
            job.status = svpwm_pkg::ST_BAD_ARG;
          end
        end
        svpwm_pkg::CMD_DIS_CH: job.kind = svpwm_pkg::JOB_OFF;
        svpwm_pkg::CMD_DIS_ALL: begin
          job.kind = svpwm_pkg::JOB_OFF;
          job.addr = svpwm_pkg::REG_ALL;
        end
        svpwm_pkg::CMD_NEUTRAL: begin
          job.kind      = svpwm_pkg::JOB_PULSE;
          job.pulse_req = cfg.pulse_neutral;
        end
        default: job.status = svpwm_pkg::ST_BAD_ARG;
      endcase
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_full && presc_ready)
    else $error("transaction taken while queue full or prescaler busy");

endmodule

`default_nettype wire

### rtl/core/svpwm_fifo.sv
`default_nettype none

module svpwm_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire svpwm_pkg::job_t push_job,
  input  wire logic            pop,
  output svpwm_pkg::job_t      pop_job,
  output logic                 full,
  output logic                 empty
);

  localparam int DEPTH = svpwm_pkg::FIFO_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  svpwm_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     count_r;

  assign full    = count_r == (AW+1)'(DEPTH);
  assign empty   = count_r == '0;
  assign pop_job = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (AW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (AW+1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue read while empty");

endmodule

`default_nettype wire

### rtl/core/svpwm_div.sv
`default_nettype none

module svpwm_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           in_v,
  input  wire logic [svpwm_pkg::REM_W-1:0]    in_rem,
  input  wire svpwm_pkg::job_t                in_job,
  input  wire logic [17:0]                    d2,
  output logic                                out_v,
  output svpwm_pkg::job_t                     out_job,
  output logic [svpwm_pkg::QW-1:0]            out_q
);

  localparam int QW    = svpwm_pkg::QW;
  localparam int REM_W = svpwm_pkg::REM_W;

  logic [REM_W-1:0] rem_r [QW];
  logic [QW-1:0]    q_r   [QW];
  svpwm_pkg::job_t  job_r [QW];
  logic [QW-1:0]    v_r;

  // one restoring step per stage, most significant quotient bit first
  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int P = (i == 0) ? 0 : i - 1;
    localparam int B = QW - 1 - i;
    logic [REM_W-1:0] rem_in, dsh;
    logic [QW-1:0]    q_in;
    svpwm_pkg::job_t  job_in;
    logic             v_in, ge;

    assign rem_in = (i == 0) ? in_rem : rem_r[P];
    assign q_in   = (i == 0) ? '0 : q_r[P];
    assign job_in = (i == 0) ? in_job : job_r[P];
    assign v_in   = (i == 0) ? in_v : v_r[P];
    assign dsh    = REM_W'(d2) << B;
    assign ge     = rem_in >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? rem_in - dsh : rem_in;
        q_r[i]   <= {q_in[QW-2:0], ge};
        job_r[i] <= job_in;
      end
    end
  end

  assign out_v   = v_r[QW-1];
  assign out_job = job_r[QW-1];
  assign out_q   = q_r[QW-1];

endmodule

`default_nettype wire

### rtl/core/svpwm_back.sv
`default_nettype none

module svpwm_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire svpwm_pkg::cfg_t cfg,
  input  wire logic [7:0]      prescale,
  input  wire logic            fifo_empty,
  input  wire svpwm_pkg::job_t fifo_job,
  output logic                 fifo_pop,
  svpwm_out_if.source          out_ch
);

  localparam int QW     = svpwm_pkg::QW;
  localparam int REM_W  = svpwm_pkg::REM_W;
  localparam int XW     = svpwm_pkg::XW;
  localparam int TICK_W = svpwm_pkg::TICK_W;
  localparam int FW     = svpwm_pkg::FREQ_W;
  localparam int PW     = TICK_W + FW;
  localparam int MW     = 65;

  logic adv;

  logic [15:0]       prange;
  logic [17:0]       den_full;
  logic [17:0]       d2;
  logic [FW-1:0]     fsat;

  logic              s0_v_r;
  svpwm_pkg::job_t   s0_job_r;
  logic [32:0]       s0_num_r;

  logic              s1_v_r;
  svpwm_pkg::job_t   s1_job_r;
  logic [REM_W-1:0]  s1_rem_r;

  logic              dv_v;
  svpwm_pkg::job_t   dv_job;
  logic [QW-1:0]     dv_q;

  logic              sp_v_r;
  svpwm_pkg::job_t   sp_job_r;
  logic [TICK_W-1:0] sp_us_r, sp_us_nxt;

  logic              t1_v_r;
  svpwm_pkg::job_t   t1_job_r;
  logic [PW-1:0]     t1_p_r;

  logic              t2_v_r;
  svpwm_pkg::job_t   t2_job_r;
  logic [XW-1:0]     t2_x_r, t2_x_nxt;
  logic              t2_sat_r;

  logic              t3_v_r;
  svpwm_pkg::job_t   t3_job_r;
  logic [TICK_W-1:0] t3_tick_r, t3_tick_nxt;
  logic [MW-1:0]     prod;

  logic              out_v_r;
  svpwm_pkg::out_t   out_r, out_nxt;

  // whole pipeline moves when the output register can take a result
  assign adv      = !out_v_r || out_ch.ready;
  assign fifo_pop = adv && !fifo_empty;

  // user keeps config stable while transactions are in flight; unchecked
  assign prange   = cfg.pulse_max - cfg.pulse_min;
  assign den_full = {cfg.angle_max[16], cfg.angle_max} - {cfg.angle_min[16], cfg.angle_min};
  assign d2       = {den_full[16:0], 1'b0};
  assign fsat     = svpwm_pkg::freq_sat(cfg.pwm_frequency);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      sp_v_r  <= 1'b0;
      t1_v_r  <= 1'b0;
      t2_v_r  <= 1'b0;
      t3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r  <= fifo_pop;
      s1_v_r  <= s0_v_r;
      sp_v_r  <= dv_v;
      t1_v_r  <= sp_v_r;
      t2_v_r  <= t1_v_r;
      t3_v_r  <= t2_v_r;
      out_v_r <= t3_v_r;
    end
  end

  // angle offset times pulse span, then rounding numerator 2*num + den
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_job_r <= fifo_job;
      s0_num_r <= 33'(fifo_job.angle_off) * 33'(prange);
      s1_job_r <= s0_job_r;
      s1_rem_r <= {1'b0, s0_num_r, 1'b0} + REM_W'(den_full[16:0]);
    end
  end

  svpwm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_v    (s1_v_r),
    .in_rem  (s1_rem_r),
    .in_job  (s1_job_r),
    .d2      (d2),
    .out_v   (dv_v),
    .out_job (dv_job),
    .out_q   (dv_q)
  );

  // pick the pulse and clamp it to the fixed PULSE_LO to PULSE_HI limits
  always_comb begin
    logic [16:0] us;
    if (dv_job.kind == svpwm_pkg::JOB_ANGLE) begin
      us = {1'b0, cfg.pulse_min} + {1'b0, dv_q};
    end else begin
      us = {1'b0, dv_job.pulse_req};
    end
    if (us < 17'(svpwm_pkg::PULSE_LO)) begin
      sp_us_nxt = TICK_W'(svpwm_pkg::PULSE_LO);
    end else if (us > 17'(svpwm_pkg::PULSE_HI)) begin
      sp_us_nxt = TICK_W'(svpwm_pkg::PULSE_HI);
    end else begin
      sp_us_nxt = us[TICK_W-1:0];
    end
  end

  // ticks = round(us * f * res / 1e6) through a reciprocal multiply
  assign t2_x_nxt = XW'(t1_p_r) * XW'(svpwm_pkg::TICK_RESOLUTION) +
                    XW'(svpwm_pkg::ROUND_HALF);
  assign prod     = MW'(t2_x_r[31:0]) * MW'(svpwm_pkg::RECIP);
  assign t3_tick_nxt = t2_sat_r ? TICK_W'(svpwm_pkg::TICK_MAX) :
                       prod[svpwm_pkg::RECIP_SH +: TICK_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      sp_job_r  <= dv_job;
      sp_us_r   <= sp_us_nxt;
      t1_job_r  <= sp_job_r;
      t1_p_r    <= PW'(sp_us_r) * PW'(fsat);
      t2_job_r  <= t1_job_r;
      t2_x_r    <= t2_x_nxt;
      t2_sat_r  <= t2_x_nxt >= XW'(svpwm_pkg::SAT_X);
      t3_job_r  <= t2_job_r;
      t3_tick_r <= t3_tick_nxt;
      out_r     <= out_nxt;
    end
  end

  // assemble the register write
  always_comb begin
    logic [TICK_W-1:0] on_t, off_t;
    logic [7:0]        hi_extra;
    on_t     = '0;
    off_t    = '0;
    hi_extra = 8'd0;
    out_nxt          = '0;
    out_nxt.status   = t3_job_r.status;
    out_nxt.prescale = prescale;
    if (t3_job_r.status == svpwm_pkg::ST_OK) begin
      case (t3_job_r.kind)
        svpwm_pkg::JOB_RAW: begin
          on_t  = t3_job_r.on_raw;
          off_t = t3_job_r.off_raw;
        end
        svpwm_pkg::JOB_OFF: hi_extra = svpwm_pkg::FULL_OFF;
        default: off_t = t3_tick_r;
      endcase
      out_nxt.write_valid = 1'b1;
      out_nxt.reg_addr    = t3_job_r.addr;
      out_nxt.on_low      = on_t[7:0];
      out_nxt.on_high     = {4'd0, on_t[TICK_W-1:8]};
      out_nxt.off_low     = off_t[7:0];
      out_nxt.off_high    = {4'd0, off_t[TICK_W-1:8]} | hi_extra;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.status      = out_r.status;
  assign out_ch.write_valid = out_r.write_valid;
  assign out_ch.reg_addr    = out_r.reg_addr;
  assign out_ch.on_low      = out_r.on_low;
  assign out_ch.on_high     = out_r.on_high;
  assign out_ch.off_low     = out_r.off_low;
  assign out_ch.off_high    = out_r.off_high;
  assign out_ch.prescale    = out_r.prescale;

  a_fail_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.status != svpwm_pkg::ST_OK |->
      !out_r.write_valid && out_r.reg_addr == 8'd0 && out_r.off_high == 8'd0)
    else $error("failed transaction carries a register write");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(t3_v_r) && $stable(out_r))
    else $error("pipeline moved while the output was stalled");

endmodule

`default_nettype wire

### bench/servo_command_to_pwm_registers_tb.sv
`default_nettype none

module servo_command_to_pwm_registers_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import svpwm_pkg::*;

  // reserved command codes the block must reject
  localparam logic [2:0] CMD_RSVD_LO = 3'd6;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;

  localparam int LATENCY     = 24;
  localparam int MAX_GAP     = 18;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 210;
  localparam int MAX_REPORTS = 100;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         channel;
    logic signed [16:0] angle;
    logic [15:0]        pulse_width;
    logic [15:0]        on_count;
    logic [15:0]        off_count;
  } servo_cmd_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  svpwm_in_if  cmd_if ();
  svpwm_out_if regs_if ();

  // expected register writes and commands waiting to be driven
  out_t       expected_regs[$];
  servo_cmd_t pending_cmds[$];

  // shadow copy of the configuration registers
  cfg_t shadow;

  logic cmd_taken  = 1'b0;
  logic regs_taken = 1'b0;
  bit   tx_fast    = 1'b0;
  bit   rx_fast    = 1'b0;
  int   tx_wait    = 0;
  int   rx_wait    = 0;
  int   hold_trigger = 0;
  int   hold_seen    = 0;
  int   hold_left    = 0;

  int mismatches      = 0;
  int cmds_accepted   = 0;
  int results_checked = 0;
  int configs_run     = 0;
  int cycle_count     = 0;
  int status_seen[4];

  servo_command_to_pwm_registers i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (cmd_if),
    .out_ch    (regs_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // frequency saturated into the supported range
  function automatic longint unsigned clamp_frequency(logic [FREQ_W-1:0] raw);
    longint unsigned f;
    f = raw;
    if (f < FREQ_MIN) f = FREQ_MIN;
    if (f > FREQ_MAX) f = FREQ_MAX;
    return f;
  endfunction

  // clamped pulse in us to off tick, rounded and saturated
  function automatic logic [TICK_W-1:0] pulse_to_off_tick(longint unsigned us,
                                                          longint unsigned f);
    longint unsigned clamped;
    longint unsigned t;
    clamped = us;
    if (clamped < PULSE_LO) clamped = PULSE_LO;
    if (clamped > PULSE_HI) clamped = PULSE_HI;
    t = (clamped * f * TICK_RESOLUTION + ROUND_HALF) / US_PER_S;
    if (t > TICK_MAX) t = TICK_MAX;
    return t[TICK_W-1:0];
  endfunction

  // rounded oscillator divider minus one, saturated to a byte
  function automatic logic [7:0] prescale_for(longint unsigned f);
    longint unsigned den;
    longint unsigned q;
    den = 64'(TICK_RESOLUTION) * f;
    q = (64'(OSC_HZ) + den / 2) / den;
    if (q == 0) return 8'h00;
    if (q - 1 > 64'hFF) return 8'hFF;
    return 8'(q - 1);
  endfunction

  // register write produced by one command under the given configuration
  function automatic out_t predict_pwm_regs(servo_cmd_t c, cfg_t k);
    out_t              r;
    status_t           st;
    logic [7:0]        addr;
    logic [TICK_W-1:0] on_t;
    logic [TICK_W-1:0] off_t;
    logic [7:0]        full_off;
    longint unsigned   f;
    longint            a;
    longint            amin;
    longint            amax;
    longint            den;
    longint            num;
    longint            p;
    r        = '0;
    st       = ST_OK;
    addr     = '0;
    on_t     = '0;
    off_t    = '0;
    full_off = '0;
    f        = clamp_frequency(k.pwm_frequency);
    a        = c.angle;
    amin     = k.angle_min;
    amax     = k.angle_max;
    // enable, then command code, then channel, then argument
    if (!k.enabled) begin
      st = ST_NOT_CONFIGURED;
    end else if (c.cmd > CMD_NEUTRAL) begin
      st = ST_BAD_ARG;
    end else if (c.cmd != CMD_DIS_ALL && c.channel >= CHANNELS) begin
      st = ST_BAD_CHANNEL;
    end else begin
      addr = (c.cmd == CMD_DIS_ALL) ? REG_ALL : 8'(REG_LED0 + 4 * c.channel);
      case (c.cmd)
        CMD_ANGLE: begin
          if (amax <= amin || k.pulse_max <= k.pulse_min) begin
            st = ST_BAD_ARG;
          end else begin
            if (a < amin) a = amin;
            if (a > amax) a = amax;
            den   = amax - amin;
            num   = (a - amin) * (longint'(k.pulse_max) - longint'(k.pulse_min));
            p     = longint'(k.pulse_min) + (2 * num + den) / (2 * den);
            off_t = pulse_to_off_tick(p, f);
          end
        end
        CMD_PULSE: begin
          off_t = pulse_to_off_tick(c.pulse_width, f);
        end
        CMD_RAW: begin
          if (c.on_count > TICK_MAX || c.off_count > TICK_MAX) begin
            st = ST_BAD_ARG;
          end else begin
            on_t  = c.on_count[TICK_W-1:0];
            off_t = c.off_count[TICK_W-1:0];
          end
        end
        CMD_NEUTRAL: begin
          off_t = pulse_to_off_tick(k.pulse_neutral, f);
        end
        CMD_DIS_CH, CMD_DIS_ALL: begin
          full_off = FULL_OFF;
        end
        default: begin
        end
      endcase
    end
    r.status = st;
    if (st == ST_OK) begin
      r.write_valid = 1'b1;
      r.reg_addr    = addr;
      r.on_low      = on_t[7:0];
      r.on_high     = {4'h0, on_t[11:8]};
      r.off_low     = off_t[7:0];
      r.off_high    = {4'h0, off_t[11:8]} | full_off;
    end
    r.prescale = prescale_for(f);
    return r;
  endfunction

  function automatic int draw_gap(bit fast);
    if (fast) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // random command, mostly aimed at the configured ranges
  function automatic servo_cmd_t random_command();
    servo_cmd_t c;
    int         lo;
    int         hi;
    int         a;
    c.cmd = ($urandom_range(0, 99) < 92) ? 3'($urandom_range(CMD_ANGLE, CMD_NEUTRAL))
                                         : 3'(CMD_RSVD_LO + $urandom_range(0, 1));
    c.channel = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, CHANNELS - 1))
                                             : 8'($urandom);
    lo = shadow.angle_min;
    hi = shadow.angle_max;
    if (hi < lo) begin
      a  = lo;
      lo = hi;
      hi = a;
    end
    case ($urandom_range(0, 3))
      0:       a = $urandom;
      1:       a = lo - 300 + $urandom_range(0, 600);
      2:       a = hi - 300 + $urandom_range(0, 600);
      default: a = lo + $urandom_range(0, hi - lo);
    endcase
    c.angle = 17'(a);
    case ($urandom_range(0, 3))
      0:       c.pulse_width = 16'($urandom);
      1:       c.pulse_width = 16'(PULSE_LO - 20 + $urandom_range(0, 40));
      2:       c.pulse_width = 16'(PULSE_HI - 20 + $urandom_range(0, 40));
      default: c.pulse_width = 16'($urandom_range(PULSE_LO, PULSE_HI));
    endcase
    c.on_count  = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, TICK_MAX))
                                              : 16'($urandom);
    c.off_count = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, TICK_MAX))
                                              : 16'($urandom);
    return c;
  endfunction

  task automatic add_cmd(logic [2:0] cmd, int ch, int ang, int pw, int onc, int offc);
    servo_cmd_t c;
    c.cmd         = cmd;
    c.channel     = 8'(ch);
    c.angle       = 17'(ang);
    c.pulse_width = 16'(pw);
    c.on_count    = 16'(onc);
    c.off_count   = 16'(offc);
    pending_cmds.push_back(c);
  endtask

  task automatic add_random(int count);
    for (int i = 0; i < count; i++) begin
      pending_cmds.push_back(random_command());
    end
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_ENABLED:       shadow.enabled       = value[0];
      CFG_PWM_FREQUENCY: shadow.pwm_frequency = value[FREQ_W-1:0];
      CFG_ANGLE_MIN:     shadow.angle_min     = value;
      CFG_ANGLE_MAX:     shadow.angle_max     = value;
      CFG_PULSE_MIN:     shadow.pulse_min     = value[15:0];
      CFG_PULSE_MAX:     shadow.pulse_max     = value[15:0];
      CFG_PULSE_NEUTRAL: shadow.pulse_neutral = value[15:0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_cfg(int en, int freq, int amin, int amax, int pmin, int pmax,
                             int pneu);
    set_reg(CFG_ENABLED, 17'(en));
    set_reg(CFG_PWM_FREQUENCY, 17'(freq));
    set_reg(CFG_ANGLE_MIN, 17'(amin));
    set_reg(CFG_ANGLE_MAX, 17'(amax));
    set_reg(CFG_PULSE_MIN, 17'(pmin));
    set_reg(CFG_PULSE_MAX, 17'(pmax));
    set_reg(CFG_PULSE_NEUTRAL, 17'(pneu));
    configs_run++;
  endtask

  // wait until every command is sent and every write has come back
  task automatic drain();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || cmd_if.valid || expected_regs.size() != 0);
  endtask

  task automatic settle();
    drain();
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want_v,
                 got_v);
      end
    end
  endtask

  // command driver, one transaction at a time with random gaps
  always @(negedge clk) begin : cmd_driver
    servo_cmd_t nxt;
    if (!rst_n) begin
      cmd_if.valid <= 1'b0;
    end else if (cmd_if.valid && !cmd_taken) begin
      // hold the offered command until it is taken
    end else if (tx_wait > 0) begin
      tx_wait--;
      cmd_if.valid <= 1'b0;
    end else if (pending_cmds.size() != 0) begin
      nxt = pending_cmds.pop_front();
      cmd_if.cmd         <= nxt.cmd;
      cmd_if.channel     <= nxt.channel;
      cmd_if.angle       <= nxt.angle;
      cmd_if.pulse_width <= nxt.pulse_width;
      cmd_if.on_count    <= nxt.on_count;
      cmd_if.off_count   <= nxt.off_count;
      cmd_if.valid       <= 1'b1;
      tx_wait = draw_gap(tx_fast);
    end else begin
      cmd_if.valid <= 1'b0;
    end
  end

  // result receiver with per transaction stalls and an occasional long hold
  always @(negedge clk) begin : regs_receiver
    if (regs_taken) rx_wait = draw_gap(rx_fast);
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      regs_if.ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      regs_if.ready <= 1'b0;
    end else begin
      regs_if.ready <= 1'b1;
    end
  end

  // sample both channels, predict on input, compare on output
  always @(posedge clk) begin : transaction_monitor
    servo_cmd_t seen;
    out_t       got;
    out_t       want;
    cmd_taken  <= rst_n && cmd_if.valid && cmd_if.ready;
    regs_taken <= rst_n && regs_if.valid && regs_if.ready;
    if (rst_n && cmd_if.valid && cmd_if.ready) begin
      seen.cmd         = cmd_if.cmd;
      seen.channel     = cmd_if.channel;
      seen.angle       = cmd_if.angle;
      seen.pulse_width = cmd_if.pulse_width;
      seen.on_count    = cmd_if.on_count;
      seen.off_count   = cmd_if.off_count;
      expected_regs.push_back(predict_pwm_regs(seen, shadow));
      cmds_accepted++;
    end
    if (rst_n && regs_if.valid && regs_if.ready) begin
      got.status      = regs_if.status;
      got.write_valid = regs_if.write_valid;
      got.reg_addr    = regs_if.reg_addr;
      got.on_low      = regs_if.on_low;
      got.on_high     = regs_if.on_high;
      got.off_low     = regs_if.off_low;
      got.off_high    = regs_if.off_high;
      got.prescale    = regs_if.prescale;
      if (expected_regs.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected register write, expected none, actual 0x%0h", $time,
                 got);
      end else begin
        want = expected_regs.pop_front();
        check_field("status", 8'(want.status), 8'(got.status));
        check_field("write_valid", 8'(want.write_valid), 8'(got.write_valid));
        check_field("reg_addr", want.reg_addr, got.reg_addr);
        check_field("on_low", want.on_low, got.on_low);
        check_field("on_high", want.on_high, got.on_high);
        check_field("off_low", want.off_low, got.off_low);
        check_field("off_high", want.off_high, got.off_high);
        check_field("prescale", want.prescale, got.prescale);
        results_checked++;
        if (!$isunknown(got.status)) status_seen[got.status]++;
      end
    end
  end

  // run length guard
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d writes outstanding", cycle_count,
             expected_regs.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int amin;
    int amax;
    int pmin;
    cmd_if.valid         = 1'b0;
    cmd_if.cmd           = CMD_ANGLE;
    cmd_if.channel       = '0;
    cmd_if.angle         = '0;
    cmd_if.pulse_width   = '0;
    cmd_if.on_count      = '0;
    cmd_if.off_count     = '0;
    regs_if.ready        = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_ENABLED;
    cfg_wdata            = '0;
    rst_n                = 1'b0;
    shadow.enabled       = 1'b0;
    shadow.pwm_frequency = 11'd50;
    shadow.angle_min     = 17'sd0;
    shadow.angle_max     = 17'sd18000;
    shadow.pulse_min     = 16'd500;
    shadow.pulse_max     = 16'd2500;
    shadow.pulse_neutral = 16'd1500;
    for (int s = 0; s < 4; s++) status_seen[s] = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // commands before the controller is enabled
    add_cmd(CMD_PULSE, 0, 0, 1500, 0, 0);
    add_cmd(CMD_DIS_ALL, 0, 0, 0, 0, 0);
    add_cmd(CMD_RSVD_HI, 255, 0, 0, 0, 0);
    settle();

    // directed: field extremes, every command, bad channel and bad argument failures
    program_cfg(1, 50, 0, 18000, 500, 2500, 1500);
    add_cmd(CMD_ANGLE, 0, -65536, 0, 0, 0);
    add_cmd(CMD_ANGLE, 15, 65535, 0, 0, 0);
    add_cmd(CMD_ANGLE, 3, 9000, 0, 0, 0);
    add_cmd(CMD_ANGLE, 5, 1, 0, 0, 0);
    add_cmd(CMD_PULSE, 1, 0, 0, 0, 0);
    add_cmd(CMD_PULSE, 2, 0, 65535, 0, 0);
    add_cmd(CMD_PULSE, 7, 0, 1500, 0, 0);
    add_cmd(CMD_RAW, 4, 0, 0, 0, TICK_MAX);
    add_cmd(CMD_RAW, 6, 0, 0, TICK_MAX, 0);
    add_cmd(CMD_RAW, 8, 0, 0, TICK_MAX + 1, 0);
    add_cmd(CMD_RAW, 9, 0, 0, 0, 65535);
    add_cmd(CMD_DIS_CH, 15, 0, 0, 0, 0);
    add_cmd(CMD_DIS_ALL, 255, 0, 0, 0, 0);
    add_cmd(CMD_NEUTRAL, 10, 0, 0, 0, 0);
    add_cmd(CMD_ANGLE, 16, 9000, 0, 0, 0);
    add_cmd(CMD_PULSE, 255, 0, 1500, 0, 0);
    add_cmd(CMD_RSVD_LO, 0, 0, 0, 0, 0);
    add_cmd(CMD_RSVD_HI, 200, 0, 0, 0, 0);
    settle();

    // empty angle range
    program_cfg(1, 50, 5000, 5000, 500, 2500, 1500);
    add_cmd(CMD_ANGLE, 2, 5000, 0, 0, 0);
    settle();

    // inverted pulse range
    program_cfg(1, 50, 0, 18000, 2500, 500, 1500);
    add_cmd(CMD_ANGLE, 11, 4500, 0, 0, 0);
    add_cmd(CMD_PULSE, 11, 0, 2000, 0, 0);
    settle();

    // random phases over several configurations
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: program_cfg(1, 50, 0, 18000, 500, 2500, 1500);
        1: program_cfg(1, FREQ_MIN, -9000, 9000, 1000, 2000, 0);
        2: program_cfg(1, FREQ_MAX, -65536, 65535, 0, 65535, 65535);
        3: program_cfg(1, 0, -36000, 36000, 700, 2300, 499);
        4: program_cfg(1, 2047, 35999, 36000, 2499, 2500, 2501);
        5: program_cfg(0, 333, -18000, 18000, 500, 2500, 1500);
        6: program_cfg(1, $urandom_range(0, 2047), $urandom, $urandom, $urandom,
                       $urandom, $urandom);
        7: begin
          amin = $urandom_range(0, 72000) - 36000;
          amax = amin + 1 + $urandom_range(0, 36000 - amin);
          pmin = $urandom_range(0, 3000);
          program_cfg(1, $urandom_range(FREQ_MIN, FREQ_MAX), amin, amax, pmin,
                      pmin + 1 + $urandom_range(0, 3000), $urandom_range(0, 3000));
        end
        default: program_cfg(1, 60, -4500, 4500, 600, 2400, 1520);
      endcase
      case (phase)
        1: begin
          // sender runs flat out while the receiver holds off
          tx_fast = 1'b1;
          add_random(PHASE_ITEMS);
          hold_trigger++;
          drain();
          tx_fast = 1'b0;
        end
        3: begin
          // sender pauses until all writes are back
          add_random(PHASE_ITEMS / 2);
          drain();
          add_random(PHASE_ITEMS / 2);
        end
        5: add_random(60);
        6: begin
          tx_fast = 1'b1;
          rx_fast = 1'b1;
          add_random(PHASE_ITEMS);
          drain();
          tx_fast = 1'b0;
          rx_fast = 1'b0;
        end
        default: add_random(PHASE_ITEMS);
      endcase
      settle();
    end

    if (expected_regs.size() != 0) mismatches++;
    $display("covered %0d commands and %0d register writes over %0d configurations",
             cmds_accepted, results_checked, configs_run);
    $display("status ok %0d, not configured %0d, bad channel %0d, bad argument %0d",
             status_seen[ST_OK], status_seen[ST_NOT_CONFIGURED],
             status_seen[ST_BAD_CHANNEL], status_seen[ST_BAD_ARG]);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
